[sv/alm_pkg.sv]
// alm_pkg: shared types, codes and constants of the audio level meter
// no dependencies; imported by alm_divsqrt and audio_level_meter
package alm_pkg;

	localparam int LEVEL_W        = 24;
	localparam int SUM_W          = 62;
	localparam int ROOT_W         = SUM_W / 2;
	localparam int SUB_W          = 34;
	localparam int PROD_W         = 40;
	localparam int DECAY_W        = 16;
	localparam int CFG_W          = 24;
	localparam int CH_FIELD_W     = 5;
	localparam int CHANNELS_DEF   = 32;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd63068;
	localparam logic [LEVEL_W-1:0] CLIP_RESET  = 24'd8388607;

	// register indexes of the configuration port
	localparam logic CFG_DECAY = 1'b0;
	localparam logic CFG_CLIP  = 1'b1;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_FINAL  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} alm_op_t;

	typedef struct packed {
		logic [1:0]               opcode;
		logic [CH_FIELD_W-1:0]    channel;
		logic signed [LEVEL_W-1:0] sample;
		logic                     active;
	} alm_in_t;

	typedef struct packed {
		logic [CH_FIELD_W-1:0] meter_channel;
		logic [LEVEL_W-1:0]    peak_level;
		logic [LEVEL_W-1:0]    rms_level;
		logic [LEVEL_W-1:0]    held_peak;
		logic                  clip_seen;
		logic                  active_out;
	} alm_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_UPD,
		ST_START,
		ST_ROOT,
		ST_FIN
	} alm_state_t;

	typedef enum logic [1:0] {
		DS_IDLE,
		DS_DIV,
		DS_SQRT
	} alm_ds_state_t;

endpackage

[sv/alm_divsqrt.sv]
// alm_divsqrt: iterative floor(sqrt(sum / count)), one bit per cycle
// one shared subtractor serves the restoring divide and the square root; uses alm_pkg
module alm_divsqrt #(
	parameter int COUNT_BITS = alm_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [alm_pkg::SUM_W-1:0]   sum,
	input  logic [COUNT_BITS-1:0]       count,
	output logic                        done,
	output logic [alm_pkg::LEVEL_W-1:0] root
);
	import alm_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);
	localparam int REM_W  = SUB_W - 2;

	alm_ds_state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [SUM_W-1:0]  work_q;
	logic [COUNT_BITS-1:0] den_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [SUB_W-1:0] sub_a, sub_b;
	logic [SUB_W:0]   sub_diff;
	logic             sub_ge;
	logic             last_div, last_sqrt;

	assign last_div  = (step_q == STEP_W'(SUM_W - 1));
	assign last_sqrt = (step_q == STEP_W'(ROOT_W - 1));

	// shared subtractor: divisor trial or root trial
	always_comb begin
		case (state_q)
			DS_DIV: begin
				sub_a = SUB_W'({rem_q[COUNT_BITS-1:0], work_q[SUM_W-1]});
				sub_b = SUB_W'(den_q);
			end
			DS_SQRT: begin
				sub_a = {rem_q, work_q[SUM_W-1:SUM_W-2]};
				sub_b = SUB_W'({root_q, 2'b01});
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge   = !sub_diff[SUB_W];

	always_comb begin
		state_d = state_q;
		case (state_q)
			DS_IDLE: if (start) state_d = DS_DIV;
			DS_DIV:  if (last_div) state_d = DS_SQRT;
			DS_SQRT: if (last_sqrt) state_d = DS_IDLE;
			default: state_d = DS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DS_SQRT) && last_sqrt;
			if (state_d != state_q)
				step_q <= '0;
			else
				step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DS_IDLE: begin
				if (start) begin
					work_q <= sum;
					den_q  <= count;
					rem_q  <= '0;
				end
			end
			DS_DIV: begin
				work_q <= {work_q[SUM_W-2:0], sub_ge};
				if (last_div) begin
					rem_q  <= '0;
					root_q <= '0;
				end else begin
					rem_q <= sub_ge ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
				end
			end
			DS_SQRT: begin
				work_q <= {work_q[SUM_W-3:0], 2'b00};
				rem_q  <= sub_ge ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], sub_ge};
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign done = done_q;
	assign root = root_q[LEVEL_W-1:0];

endmodule

[sv/audio_level_meter.sv]
// audio_level_meter: per-channel peak, rms and peak-hold meter, top level
// depends on alm_pkg and alm_divsqrt
//
// channel   direction  handshake            payload
// in        sink       in_valid/in_ready    in_word  (alm_in_t)
// out       source     out_valid/out_ready  out_word (alm_out_t)
// cfg       sink       cfg_we               cfg_index, cfg_data
//
// a sample word passes through address capture, memory read plus squaring, and update
// a finalise word with no samples goes from read through start to finish without the root unit; else the divide
// (SUM_W steps) and square root (SUM_W/2 steps) share one subtractor, one bit a cycle
// a clear word and an ignored word are taken in the idle state without entering the sequencer
// reset clears control, clip flags and per-channel valid bits and loads config defaults; no clearing pass
// out_ready low with a word pending holds only a finalise at its last step; the input side waits meanwhile
module audio_level_meter #(
	parameter int CHANNELS   = alm_pkg::CHANNELS_DEF,
	parameter int COUNT_BITS = alm_pkg::COUNT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  alm_pkg::alm_in_t          in_word,
	output logic                      out_valid,
	input  logic                      out_ready,
	output alm_pkg::alm_out_t         out_word,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [alm_pkg::CFG_W-1:0] cfg_data
);
	import alm_pkg::*;

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int WIDE_W = 9;

	// configuration registers
	logic [DECAY_W-1:0] decay_q;
	logic [LEVEL_W-1:0] clip_lvl_q;

	// sequencer
	alm_state_t state_q, state_d;
	alm_in_t    item_q;
	logic [CH_W-1:0] idx_q;

	// per-channel stores: memories plus valid bits (invalid reads as zero)
	logic [LEVEL_W-1:0]    peak_mem [CHANNELS];
	logic [SUM_W-1:0]      sum_mem  [CHANNELS];
	logic [COUNT_BITS-1:0] cnt_mem  [CHANNELS];
	logic [LEVEL_W-1:0]    hold_mem [CHANNELS];
	logic [CHANNELS-1:0]   vld_q;
	logic [CHANNELS-1:0]   clip_flag_q;

	logic [LEVEL_W-1:0]    rd_peak_q, rd_hold_q;
	logic [SUM_W-1:0]      rd_sum_q;
	logic [COUNT_BITS-1:0] rd_cnt_q;
	logic                  rd_vld_q;

	logic [LEVEL_W-1:0]    row_peak, row_hold;
	logic [SUM_W-1:0]      row_sum;
	logic [COUNT_BITS-1:0] row_cnt;

	// arithmetic
	logic [LEVEL_W-1:0]   mag;
	logic [2*LEVEL_W-1:0] sq_q;
	logic [PROD_W-1:0]    prod_q;
	logic [SUM_W:0]       sum_add;
	logic [SUM_W-1:0]     new_sum;
	logic [COUNT_BITS-1:0] new_cnt;
	logic [LEVEL_W-1:0]   new_peak, hold_new;

	logic [LEVEL_W-1:0]    wr_peak, wr_hold;
	logic [SUM_W-1:0]      wr_sum;
	logic [COUNT_BITS-1:0] wr_cnt;

	logic [WIDE_W-1:0] ch_wide;
	logic in_range, accept, go_item;
	logic ds_start, ds_done, fin_go, mem_we, cnt_zero;
	logic [LEVEL_W-1:0] ds_root;

	logic     out_valid_q;
	alm_out_t out_q;

	assign ch_wide  = WIDE_W'(in_word.channel);
	assign in_range = ch_wide < WIDE_W'(CHANNELS);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign go_item  = accept && in_range &&
		(in_word.opcode == OP_SAMPLE || in_word.opcode == OP_FINAL);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q    <= DECAY_RESET;
			clip_lvl_q <= CLIP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DECAY: decay_q    <= cfg_data[DECAY_W-1:0];
				CFG_CLIP:  clip_lvl_q <= cfg_data[LEVEL_W-1:0];
				default:   decay_q    <= decay_q;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (go_item) state_d = ST_RD;
			ST_RD:    state_d = (item_q.opcode == OP_SAMPLE) ? ST_UPD : ST_START;
			ST_UPD:   state_d = ST_IDLE;
			ST_START: state_d = cnt_zero ? ST_FIN : ST_ROOT;
			ST_ROOT:  if (ds_done) state_d = ST_FIN;
			ST_FIN:   if (fin_go) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ds_start = (state_q == ST_START) && !cnt_zero;
		fin_go   = (state_q == ST_FIN) && (!out_valid_q || out_ready);
		mem_we   = (state_q == ST_UPD) || fin_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_word;
			idx_q  <= ch_wide[CH_W-1:0];
		end
	end

	// stores: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			peak_mem[idx_q] <= wr_peak;
			sum_mem[idx_q]  <= wr_sum;
			cnt_mem[idx_q]  <= wr_cnt;
			hold_mem[idx_q] <= wr_hold;
		end
		rd_peak_q <= peak_mem[idx_q];
		rd_sum_q  <= sum_mem[idx_q];
		rd_cnt_q  <= cnt_mem[idx_q];
		rd_hold_q <= hold_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[idx_q];
			if (mem_we)
				vld_q[idx_q] <= 1'b1;
		end
	end

	assign row_peak = rd_vld_q ? rd_peak_q : '0;
	assign row_sum  = rd_vld_q ? rd_sum_q  : '0;
	assign row_cnt  = rd_vld_q ? rd_cnt_q  : '0;
	assign row_hold = rd_vld_q ? rd_hold_q : '0;
	assign cnt_zero = (row_cnt == '0);

	// sample path: magnitude, square registered, saturating accumulate
	assign mag = item_q.sample[LEVEL_W-1] ? (~item_q.sample + 1'b1) : item_q.sample;

	always_ff @(posedge clk) begin
		if (state_q == ST_RD)
			sq_q <= mag * mag;
		if (state_q == ST_START)
			prod_q <= row_hold * decay_q;
	end

	assign sum_add  = {1'b0, row_sum} + (SUM_W + 1)'(sq_q);
	assign new_sum  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
	assign new_cnt  = row_cnt + 1'b1;
	assign new_peak = (mag > row_peak) ? mag : row_peak;

	// hold latches the peak, else decays by the q0.16 factor
	assign hold_new = (row_peak >= row_hold) ? row_peak : prod_q[PROD_W-1:DECAY_W];

	always_comb begin
		if (state_q == ST_FIN) begin
			wr_peak = '0;
			wr_sum  = '0;
			wr_cnt  = '0;
			wr_hold = hold_new;
		end else begin
			wr_peak = new_peak;
			// a saturated count freezes sum and count
			wr_sum  = (&row_cnt) ? row_sum : new_sum;
			wr_cnt  = (&row_cnt) ? row_cnt : new_cnt;
			wr_hold = row_hold;
		end
	end

	// sticky clip flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clip_flag_q <= '0;
		else if (accept && in_word.opcode == OP_CLEAR)
			clip_flag_q <= '0;
		else if (state_q == ST_UPD && mag >= clip_lvl_q)
			clip_flag_q[idx_q] <= 1'b1;
	end

	alm_divsqrt #(
		.COUNT_BITS(COUNT_BITS)
	) u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ds_start),
		.sum    (row_sum),
		.count  (row_cnt),
		.done   (ds_done),
		.root   (ds_root)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fin_go)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_q.meter_channel <= item_q.channel;
			out_q.peak_level    <= row_peak;
			out_q.rms_level     <= cnt_zero ? '0 : ds_root;
			out_q.held_peak     <= hold_new;
			out_q.clip_seen     <= clip_flag_q[idx_q];
			out_q.active_out    <= item_q.active;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// root unit finishes only while the sequencer waits for it
	a_done_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		ds_done |-> state_q == ST_ROOT)
		else $error("root done outside wait state");

	// a finished finalise always shows a word next cycle
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> out_valid)
		else $error("finalise lost its output word");

	// the store is written only for a word taken into the sequencer
	a_we_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !in_ready)
		else $error("store write while idle");

endmodule
